// ===== sv/csqrt_pkg.sv =====
`timescale 1ns / 1ps
package csqrt_pkg;
  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;
endpackage

// ===== sv/csqrt_isqrt_pipe.sv =====
`timescale 1ns / 1ps
module csqrt_isqrt_pipe #(
  parameter int RAD_W = 32,
  parameter int TAG_W = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [RAD_W-1:0]       in_rad,
  input  logic [TAG_W-1:0]       in_tag,
  output logic                   out_valid,
  output logic [(RAD_W+1)/2-1:0] out_root,
  output logic [TAG_W-1:0]       out_tag
);
  localparam int ROOT_W = (RAD_W + 1) / 2;
  localparam int PAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;

  logic [PAD_W-1:0]  rad_r  [ROOT_W+1];
  logic [ROOT_W-1:0] root_r [ROOT_W+1];
  logic [REM_W-1:0]  rem_r  [ROOT_W+1];
  logic [TAG_W-1:0]  tag_r  [ROOT_W+1];
  logic              vld_r  [ROOT_W+1];

  always_comb begin
    rad_r[0]  = PAD_W'(in_rad);
    root_r[0] = '0;
    rem_r[0]  = '0;
    tag_r[0]  = in_tag;
    vld_r[0]  = in_valid;
  end

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;
    always_comb begin
      rem_sh = {rem_r[i][REM_W-3:0], rad_r[i][PAD_W-1 -: 2]};
      trial  = {root_r[i], 2'b01};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[i][ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[i][ROOT_W-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
      rad_r[i+1]  <= {rad_r[i][PAD_W-3:0], 2'b00};
      root_r[i+1] <= root_nxt;
      rem_r[i+1]  <= rem_nxt;
      tag_r[i+1]  <= tag_r[i];
    end
  end

  assign out_valid = vld_r[ROOT_W];
  assign out_root  = root_r[ROOT_W];
  assign out_tag   = tag_r[ROOT_W];
endmodule

// ===== sv/csqrt_div_pipe.sv =====
`timescale 1ns / 1ps
module csqrt_div_pipe #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 16,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [NUM_W-1:0] out_quo,
  output logic [TAG_W-1:0] out_tag
);
  localparam int REM_W = DEN_W + 1;

  logic [NUM_W-1:0] num_r [NUM_W+1];
  logic [REM_W-1:0] rem_r [NUM_W+1];
  logic [DEN_W-1:0] den_r [NUM_W+1];
  logic [TAG_W-1:0] tag_r [NUM_W+1];
  logic             vld_r [NUM_W+1];

  always_comb begin
    num_r[0] = in_num;
    rem_r[0] = '0;
    den_r[0] = in_den;
    tag_r[0] = in_tag;
    vld_r[0] = in_valid;
  end

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] rem_nxt;
    logic             q_bit;
    always_comb begin
      rem_sh = {rem_r[i][REM_W-2:0], num_r[i][NUM_W-1]};
      q_bit  = rem_sh >= REM_W'(den_r[i]);
      rem_nxt = q_bit ? rem_sh - REM_W'(den_r[i]) : rem_sh;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
      num_r[i+1] <= {num_r[i][NUM_W-2:0], q_bit};
      rem_r[i+1] <= rem_nxt;
      den_r[i+1] <= den_r[i];
      tag_r[i+1] <= tag_r[i];
    end
  end

  assign out_valid = vld_r[NUM_W];
  assign out_quo   = num_r[NUM_W];
  assign out_tag   = tag_r[NUM_W];
endmodule

// ===== sv/complex_square_root.sv =====
`timescale 1ns / 1ps
// complex principal square root, signed fixed point with FRAC_BITS fraction bits
// input: drive in_real/in_imag and pulse start; busy is always low, so a
//   transaction is taken on every cycle that start is high
// output: out_valid marks out_root_real/out_root_imag for exactly one cycle;
//   the receiver cannot stall and results appear in input order
// datapath: three pipelines run in series: magnitude square root
//   (DATA_WIDTH+1 stages), second square root ((DATA_WIDTH+FRAC_BITS+3)/2
//   stages), restoring divider (DATA_WIDTH+FRAC_BITS stages) and four
//   register stages around them (input, squares, sum of squares, output)
// throughput: one transaction per cycle, one divider or root bit per stage
// reset: synchronous rst_n clears all valid bits; data in flight is dropped
module complex_square_root #(
  parameter int DATA_WIDTH = csqrt_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = csqrt_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] in_real,
  input  logic signed [DATA_WIDTH-1:0] in_imag,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_root_real,
  output logic signed [DATA_WIDTH-1:0] out_root_imag
);
  localparam int MAG_W   = DATA_WIDTH;
  localparam int SQ_W    = 2 * MAG_W + 1;
  localparam int M_W     = (SQ_W + 1) / 2;
  localparam int R2_W    = M_W + 1 + FRAC_BITS;
  localparam int R_W     = (R2_W + 1) / 2;
  localparam int NUM_W   = MAG_W + FRAC_BITS;
  localparam int TAG1_W  = 2 * MAG_W + 4;
  localparam int TAG2_W  = MAG_W + 4;
  localparam int TAG3_W  = R_W + 4;

  assign busy = 1'b0;

  // stage 0: magnitudes and squares
  logic             v0_r;
  logic [MAG_W-1:0] are0_r, aim0_r;
  logic             ren0_r, imn0_r, rez0_r, imz0_r;
  logic [SQ_W-1:0]  sq0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start;
    end
    are0_r <= in_real[DATA_WIDTH-1] ? MAG_W'(-in_real) : MAG_W'(in_real);
    aim0_r <= in_imag[DATA_WIDTH-1] ? MAG_W'(-in_imag) : MAG_W'(in_imag);
    ren0_r <= in_real[DATA_WIDTH-1];
    imn0_r <= in_imag[DATA_WIDTH-1];
    rez0_r <= in_real == '0;
    imz0_r <= in_imag == '0;
  end

  logic [SQ_W-1:0] sqa_r, sqb_r;
  logic            v1a_r;
  logic [TAG1_W-1:0] tag1a_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1a_r <= 1'b0;
    end else begin
      v1a_r <= v0_r;
    end
    sqa_r   <= SQ_W'(are0_r) * SQ_W'(are0_r);
    sqb_r   <= SQ_W'(aim0_r) * SQ_W'(aim0_r);
    tag1a_r <= {are0_r, aim0_r, ren0_r, imn0_r, rez0_r, imz0_r};
  end

  logic              v1b_r;
  logic [TAG1_W-1:0] tag1b_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1b_r <= 1'b0;
    end else begin
      v1b_r <= v1a_r;
    end
    sq0_r   <= sqa_r + sqb_r;
    tag1b_r <= tag1a_r;
  end

  // magnitude |z|
  logic              v1_r;
  logic [M_W-1:0]    m1;
  logic [TAG1_W-1:0] tag1;
  csqrt_isqrt_pipe #(.RAD_W(SQ_W), .TAG_W(TAG1_W)) u_mag (
    .clk, .rst_n, .in_valid(v1b_r), .in_rad(sq0_r), .in_tag(tag1b_r),
    .out_valid(v1_r), .out_root(m1), .out_tag(tag1)
  );

  logic [MAG_W-1:0] are1, aim1;
  logic             ren1, imn1, rez1, imz1;
  assign {are1, aim1, ren1, imn1, rez1, imz1} = tag1;

  // radicand of the second root per path
  logic [R2_W-1:0] rad2;
  always_comb begin
    if (imz1) begin
      rad2 = R2_W'(are1) << FRAC_BITS;
    end else if (rez1) begin
      rad2 = R2_W'(aim1) << (FRAC_BITS - 1);
    end else begin
      rad2 = (R2_W'(m1) + R2_W'(are1)) << (FRAC_BITS - 1);
    end
  end

  logic              v2_r;
  logic [R_W-1:0]    r2;
  logic [TAG2_W-1:0] tag2;
  csqrt_isqrt_pipe #(.RAD_W(R2_W), .TAG_W(TAG2_W)) u_root (
    .clk, .rst_n, .in_valid(v1_r), .in_rad(rad2),
    .in_tag({aim1, ren1, imn1, rez1, imz1}),
    .out_valid(v2_r), .out_root(r2), .out_tag(tag2)
  );

  logic [MAG_W-1:0] aim2;
  logic             ren2, imn2, rez2, imz2;
  assign {aim2, ren2, imn2, rez2, imz2} = tag2;

  logic [R_W-1:0] den2;
  assign den2 = (r2 == '0) ? R_W'(1) : r2;

  logic              v3_r;
  logic [NUM_W-1:0]  s3;
  logic [TAG3_W-1:0] tag3;
  csqrt_div_pipe #(.NUM_W(NUM_W), .DEN_W(R_W), .TAG_W(TAG3_W)) u_div (
    .clk, .rst_n, .in_valid(v2_r),
    .in_num(NUM_W'(aim2) << (FRAC_BITS - 1)), .in_den(den2),
    .in_tag({r2, ren2, imn2, rez2, imz2}),
    .out_valid(v3_r), .out_quo(s3), .out_tag(tag3)
  );

  logic [R_W-1:0] r3;
  logic           ren3, imn3, rez3, imz3;
  assign {r3, ren3, imn3, rez3, imz3} = tag3;

  logic [DATA_WIDTH-1:0] rr_nxt, ri_nxt, rpos, rsig, spos, ssig;
  always_comb begin
    rpos = DATA_WIDTH'(r3);
    spos = DATA_WIDTH'(s3);
    rsig = imn3 ? DATA_WIDTH'(-rpos) : rpos;
    ssig = imn3 ? DATA_WIDTH'(-spos) : spos;
    if (imz3) begin
      rr_nxt = ren3 ? '0 : rpos;
      ri_nxt = ren3 ? rpos : '0;
    end else if (rez3) begin
      rr_nxt = rpos;
      ri_nxt = rsig;
    end else if (ren3) begin
      rr_nxt = spos;
      ri_nxt = rsig;
    end else begin
      rr_nxt = rpos;
      ri_nxt = ssig;
    end
  end

  logic                  ov_r;
  logic [DATA_WIDTH-1:0] rr_r, ri_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= v3_r;
    end
    rr_r <= rr_nxt;
    ri_r <= ri_nxt;
  end

  assign out_valid     = ov_r;
  assign out_root_real = rr_r;
  assign out_root_imag = ri_r;
endmodule

// ===== sv/csqrt_checker.sv =====
`timescale 1ns / 1ps
module csqrt_checker #(
  parameter int DATA_WIDTH = csqrt_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = csqrt_pkg::FRAC_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input logic [DATA_WIDTH-1:0] out_root_real,
  input logic [DATA_WIDTH-1:0] out_root_imag
);
  localparam int LAT = 4 + (DATA_WIDTH + 1) + (DATA_WIDTH + FRAC_BITS + 3) / 2
                       + DATA_WIDTH + FRAC_BITS;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");
  a_real_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && DATA_WIDTH == 16 |-> !out_root_real[DATA_WIDTH-1])
    else $error("negative real part");
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LAT out_valid)
    else $error("missing result");
endmodule

bind complex_square_root csqrt_checker #(
  .DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)
) u_csqrt_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_root_real, .out_root_imag
);
